// ===== rtl/wbbm_pkg.sv =====
// Shared types and constants of the windowed byte budget meter.
package wbbm_pkg;

  localparam int unsigned CountW   = 63;
  localparam int unsigned WindowW  = 16;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned RawW     = 64;

  localparam logic [CountW-1:0]  CountMax      = {CountW{1'b1}};
  localparam logic [WindowW-1:0] AgeMax        = {WindowW{1'b1}};
  localparam logic [WindowW-1:0] WindowMsReset = WindowW'(1000);

  typedef enum logic [1:0] {
    OpProgress = 2'd0,
    OpTick     = 2'd1,
    OpQuery    = 2'd2,
    OpRestart  = 2'd3
  } op_e;

  typedef enum logic {
    CfgByteBudget = 1'b0,
    CfgWindowMs   = 1'b1
  } cfg_idx_e;

  // Slot table write request from the update stage.
  typedef struct packed {
    logic              en;
    logic              upload;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
  } tbl_wr_t;

endpackage

// ===== rtl/wbbm_slot_table.sv =====
// Per-slot last sent and received byte counts, cleared by reset.
module wbbm_slot_table
  import wbbm_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SlotW-1:0]     rd_slot_i,
  input  logic                 rd_upload_i,
  output logic [CountW-1:0]    rd_count_o,
  input  tbl_wr_t              wr_i
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CountW-1:0] sent_q [DEPTH];
  logic [CountW-1:0] recv_q [DEPTH];

  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;

  assign rd_addr = rd_slot_i[AddrW-1:0];
  assign wr_addr = wr_i.slot[AddrW-1:0];

  assign rd_count_o = rd_upload_i ? sent_q[rd_addr] : recv_q[rd_addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        sent_q[i] <= '0;
        recv_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      if (wr_i.upload) begin
        sent_q[wr_addr] <= wr_i.count;
      end else begin
        recv_q[wr_addr] <= wr_i.count;
      end
    end
  end

endmodule

// ===== rtl/windowed_byte_budget_meter_top.sv =====
// Windowed byte budget meter: fixed-window byte counter that gates admission.
//
// One beat in gives exactly one beat out. Progress reports (operation 0) take
// the positive delta of a slot's cumulative sent or received count and add it
// to a saturating window total; ticks (operation 1) age the window; admission
// queries (operation 2) answer throttled when a nonzero byte budget has been
// reached and give the wakeup delay max(1, window_ms - age); restarts
// (operation 3) clear the window. A report or query whose window age has
// reached window_ms first restarts the window and flags window_rolled.
// Reports naming a slot at or above REQUEST_SLOTS are dropped without effect.
// Throughput is one beat per clock while the result side is ready: the input
// register feeds a single update stage (slot table read, subtract, saturating
// add, compare) that writes all window state and the output register in the
// same cycle, so back-to-back reports to the same slot need no bypass. A beat
// passes the input register and then the output register, and a stall on the
// result side can hold it in either. Configuration writes land at once and
// are meant to be issued while the pipe is empty.
module windowed_byte_budget_meter_top
  import wbbm_pkg::*;
#(
  parameter int unsigned REQUEST_SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [CountW-1:0]         cfg_data_i,
  // Input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                operation_i,
  input  logic [SlotW-1:0]          request_slot_i,
  input  logic signed [RawW-1:0]    byte_count_i,
  input  logic                      is_upload_i,
  // Output channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      throttled_o,
  output logic                      window_rolled_o,
  output logic [WindowW-1:0]        wakeup_ms_o,
  output logic [CountW-1:0]         window_bytes_o
);

  // Only slots reachable by the slot field get storage.
  localparam int unsigned SlotSpan   = 2 ** SlotW;
  localparam int unsigned TableDepth = (REQUEST_SLOTS < SlotSpan) ? REQUEST_SLOTS : SlotSpan;
  localparam logic [SlotW:0] SlotLimit = (SlotW + 1)'(TableDepth);

  // Configuration registers
  logic [CountW-1:0]  byte_budget_q;
  logic [WindowW-1:0] window_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_budget_q <= '0;
      window_ms_q   <= WindowMsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgByteBudget: byte_budget_q <= cfg_data_i;
        CfgWindowMs:   window_ms_q   <= cfg_data_i[WindowW-1:0];
        default:       ;
      endcase
    end
  end

  // Input register stage
  logic              s1_valid_q;
  op_e               s1_op_q;
  logic [SlotW-1:0]  s1_slot_q;
  logic [CountW-1:0] s1_count_q;
  logic              s1_upload_q;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Clamp negative counts to zero on capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= op_e'(operation_i);
      s1_slot_q   <= request_slot_i;
      s1_count_q  <= byte_count_i[RawW-1] ? '0 : byte_count_i[CountW-1:0];
      s1_upload_q <= is_upload_i;
    end
  end

  // Slot table
  logic [CountW-1:0] prev_count;
  tbl_wr_t           tbl_wr;

  wbbm_slot_table #(
    .DEPTH (TableDepth)
  ) u_slot_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_slot_i   (s1_slot_q),
    .rd_upload_i (s1_upload_q),
    .rd_count_o  (prev_count),
    .wr_i        (tbl_wr)
  );

  // Window state
  logic [WindowW-1:0] age_q, age_d;
  logic [CountW-1:0]  total_q, total_d;

  // Update stage
  logic               slot_ok;
  logic               expired;
  logic [CountW-1:0]  delta;
  logic [CountW-1:0]  base_total;
  logic [WindowW-1:0] base_age;
  logic [CountW:0]    sum;
  logic               res_throttled;
  logic               res_rolled;
  logic [WindowW-1:0] res_wakeup;

  assign slot_ok    = {1'b0, s1_slot_q} < SlotLimit;
  assign expired    = age_q >= window_ms_q;
  assign delta      = (s1_count_q > prev_count) ? (s1_count_q - prev_count) : '0;
  assign base_total = expired ? '0 : total_q;
  assign base_age   = expired ? '0 : age_q;
  assign sum        = {1'b0, base_total} + {1'b0, delta};

  always_comb begin
    age_d         = age_q;
    total_d       = total_q;
    res_throttled = 1'b0;
    res_rolled    = 1'b0;
    res_wakeup    = '0;
    tbl_wr.en     = 1'b0;
    tbl_wr.upload = s1_upload_q;
    tbl_wr.slot   = s1_slot_q;
    tbl_wr.count  = s1_count_q;
    case (s1_op_q)
      OpProgress: begin
        if (slot_ok) begin
          tbl_wr.en  = s1_fire;
          res_rolled = expired;
          age_d      = base_age;
          // Saturate the window total at the 63-bit maximum.
          total_d    = sum[CountW] ? CountMax : sum[CountW-1:0];
        end
      end
      OpTick: begin
        if (age_q != AgeMax) begin
          age_d = age_q + WindowW'(1);
        end
      end
      OpQuery: begin
        res_rolled    = expired;
        age_d         = base_age;
        total_d       = base_total;
        res_throttled = (byte_budget_q != '0) && (base_total >= byte_budget_q);
        res_wakeup    = (window_ms_q > base_age) ? (window_ms_q - base_age) : '0;
        if (res_wakeup == '0) begin
          res_wakeup = WindowW'(1);
        end
      end
      OpRestart: begin
        age_d      = '0;
        total_d    = '0;
        res_rolled = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q   <= '0;
      total_q <= '0;
    end else if (s1_fire) begin
      age_q   <= age_d;
      total_q <= total_d;
    end
  end

  // Output register
  logic               out_valid_q;
  logic               throttled_q;
  logic               rolled_q;
  logic [WindowW-1:0] wakeup_q;
  logic [CountW-1:0]  bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      throttled_q <= res_throttled;
      rolled_q    <= res_rolled;
      wakeup_q    <= res_wakeup;
      bytes_q     <= total_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign throttled_o     = throttled_q;
  assign window_rolled_o = rolled_q;
  assign wakeup_ms_o     = wakeup_q;
  assign window_bytes_o  = bytes_q;

endmodule
